// ===== hdl/rwms_pkg.sv =====
// rwms_pkg: shared types and constants for the rolling window mean/deviation unit.
// No dependencies; imported by every module in hdl/.
package rwms_pkg;

	localparam int RWMS_DEPTH_DEF = 32;
	localparam int RWMS_SAMPLE_W  = 16;
	localparam int RWMS_MEAN_W    = 24;
	localparam int RWMS_SD_W      = 24;
	localparam int RWMS_CNT_W     = 6;
	// radicand width for the root: variance * 2^16 stays below 2^47
	localparam int RWMS_X_W       = 48;
	localparam int RWMS_FRAC_W    = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_MLOAD,
		ST_MUL,
		ST_VSTART,
		ST_VDIV,
		ST_ROOT,
		ST_OUT
	} rwms_state_t;

endpackage

// ===== hdl/rwms_div.sv =====
// rwms_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on rwms_pkg.
module rwms_div
	import rwms_pkg::*;
#(
	parameter int NW = 32,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     trial;
	logic            ge;
	logic [DW:0]     diff;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/rwms_sqrt.sv =====
// rwms_sqrt: digit-serial integer square root, two radicand bits per cycle.
// Depends on rwms_pkg.
module rwms_sqrt
	import rwms_pkg::*;
#(
	parameter int XW = RWMS_X_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [XW-1:0]   x,
	output logic            done,
	output logic [XW/2-1:0] root
);

	localparam int RW   = XW / 2;
	localparam int REMW = RW + 2;
	localparam int CNTW = $clog2(RW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [XW-1:0]   x_q;
	logic [REMW-1:0] rem_q;
	logic [RW-1:0]   root_q;
	logic [REMW+1:0] shifted;
	logic [REMW+1:0] trial;
	logic            ge;
	logic [REMW+1:0] diff;

	assign shifted = {rem_q, x_q[XW-1 -: 2]};
	assign trial   = (REMW + 2)'({root_q, 2'b01});
	assign ge      = shifted >= trial;
	assign diff    = shifted - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[XW-3:0], 2'b00};
			rem_q  <= ge ? diff[REMW-1:0] : shifted[REMW-1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/rolling_window_mean_stddev_unit.sv =====
// rolling_window_mean_stddev_unit: top level, window ring, running sums and sequencer.
// Depends on rwms_pkg, rwms_div and rwms_sqrt.
//
// Usage notes
// - Input channel in_valid/in_ready carries one word: sample (signed 16) and clear.
//   clear=1 empties the window and ignores sample; clear=0 pushes sample, dropping
//   the oldest once WINDOW_DEPTH samples are held.
// - Output channel out_valid/out_ready returns one word per input word: mean
//   (signed Q15.8, rounded half away from zero), std_dev (unsigned Q16.8, population,
//   truncated), sample_count and empty_res. An empty window gives empty_res=1, rest 0.
// - One word at a time: a push is accepted only after the previous word's result
//   has been loaded into the output register. The serial variance divide (one bit
//   a cycle) takes most of the processing time, then the root (two bits a cycle)
//   and the shift-add multiply. A clear skips the arithmetic and goes straight to
//   the output stage.
// - The result sits in an output register, so the next word is accepted while the
//   previous result waits; if the receiver still stalls when the next result is
//   done, the sequencer holds it until the register frees.
// - Reset (arst_n low) empties the window and drops any pending result. The sample
//   memory is not cleared; entries are only read after they are written.
module rolling_window_mean_stddev_unit
	import rwms_pkg::*;
#(
	parameter int WINDOW_DEPTH = RWMS_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [RWMS_SAMPLE_W-1:0] sample,
	input  logic                            clear,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [RWMS_MEAN_W-1:0]   mean,
	output logic [RWMS_SD_W-1:0]            std_dev,
	output logic [RWMS_CNT_W-1:0]           sample_count,
	output logic                            empty_res
);

	// widths that follow from the window depth
	localparam int CW    = $clog2(WINDOW_DEPTH + 1);          // count 0..DEPTH
	localparam int PW    = $clog2(WINDOW_DEPTH);              // ring pointer
	localparam int SUMW  = RWMS_SAMPLE_W + CW;                // signed running sum
	localparam int SQW   = 2 * RWMS_SAMPLE_W - 2 + CW;        // sum of squares
	localparam int VW    = SQW + CW;                          // n*sumsq, sum^2
	localparam int MNW   = SUMW + RWMS_FRAC_W;                // mean dividend
	localparam int VNW   = VW + 16;                           // variance dividend
	localparam int MCNTW = $clog2(SUMW + 1);

	rwms_state_t state_q, state_nx;

	// window ring and running sums
	logic signed [RWMS_SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
	logic signed [RWMS_SAMPLE_W-1:0] rd_q;
	logic signed [RWMS_SAMPLE_W-1:0] samp_q;
	logic [PW-1:0]                   wpos_q;
	logic                            full_q;
	logic signed [SUMW-1:0]          sum_q;
	logic [SQW-1:0]                  sq_q;
	logic                            empty_q;

	logic signed [2*RWMS_SAMPLE_W-1:0] sqr_new;
	logic signed [2*RWMS_SAMPLE_W-1:0] sqr_old;
	logic [CW-1:0]                     n_cur;

	// serial multiply and division operands
	logic [CW-1:0]     n_q;
	logic [2*CW-1:0]   nn_q;
	logic              neg_q;
	logic [SUMW-1:0]   abs_q;
	logic [SUMW-1:0]   abs_sum;
	logic [VW-1:0]     mca_q, acca_q;
	logic [SUMW-1:0]   mpa_q;
	logic [VW-1:0]     mcb_q, accb_q;
	logic [CW-1:0]     mpb_q;
	logic [MCNTW-1:0]  mcnt_q;
	logic [VW-1:0]     var_num;

	// output register
	logic                          out_valid_q;
	logic [RWMS_MEAN_W-1:0]        mean_q;
	logic [RWMS_SD_W-1:0]          sd_q;
	logic [RWMS_CNT_W-1:0]         cnt_q;
	logic                          empty_res_q;
	logic [RWMS_MEAN_W-1:0]        m24;

	// control strobes
	logic in_acc, mem_we, md_start, vd_start, out_load;
	logic md_busy, md_done, vd_busy, vd_done, rt_done;
	logic [MNW-1:0]             md_quo;
	logic [VNW-1:0]             vd_quo;
	logic [RWMS_X_W/2-1:0]      rt_root;

	assign in_acc = in_valid && in_ready;

	// ---------------- sequencer ----------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nx = clear ? ST_OUT : ST_READ;
			ST_READ:   state_nx = ST_UPD;
			ST_UPD:    state_nx = ST_MLOAD;
			ST_MLOAD:  state_nx = ST_MUL;
			ST_MUL:    if (mcnt_q == MCNTW'(1)) state_nx = ST_VSTART;
			ST_VSTART: state_nx = ST_VDIV;
			ST_VDIV:   if (vd_done) state_nx = ST_ROOT;
			ST_ROOT:   if (rt_done) state_nx = ST_OUT;
			ST_OUT:    if (!out_valid_q || out_ready) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_we   = 1'b0;
		md_start = 1'b0;
		vd_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_UPD:    mem_we   = 1'b1;
			ST_VSTART: begin
				md_start = 1'b1;
				vd_start = 1'b1;
			end
			ST_OUT:    out_load = !out_valid_q || out_ready;
			default:   in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ---------------- window ring ----------------
	// registered read of the slot about to be overwritten (the oldest once full)
	always_ff @(posedge clk) begin
		if (mem_we) begin
			win_mem[wpos_q] <= samp_q;
		end
		rd_q <= win_mem[wpos_q];
	end

	assign sqr_new = (2*RWMS_SAMPLE_W)'(samp_q) * (2*RWMS_SAMPLE_W)'(samp_q);
	assign sqr_old = (2*RWMS_SAMPLE_W)'(rd_q) * (2*RWMS_SAMPLE_W)'(rd_q);
	assign n_cur   = full_q ? CW'(WINDOW_DEPTH) : CW'(wpos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			full_q  <= 1'b0;
			sum_q   <= '0;
			sq_q    <= '0;
			empty_q <= 1'b1;
		end else if (in_acc) begin
			empty_q <= clear;
			if (clear) begin
				wpos_q <= '0;
				full_q <= 1'b0;
				sum_q  <= '0;
				sq_q   <= '0;
			end
		end else if (mem_we) begin
			// evict the oldest sample once the ring has wrapped
			sum_q <= sum_q + SUMW'(samp_q) - (full_q ? SUMW'(rd_q) : SUMW'(0));
			sq_q  <= sq_q + SQW'($unsigned(sqr_new))
				- (full_q ? SQW'($unsigned(sqr_old)) : SQW'(0));
			if (wpos_q == PW'(WINDOW_DEPTH - 1)) begin
				wpos_q <= '0;
				full_q <= 1'b1;
			end else begin
				wpos_q <= wpos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_q <= sample;
		end
	end

	// ---------------- shift-add squarers ----------------
	// acca: |sum|^2, accb: n*sumsq, one multiplier bit per cycle
	assign abs_sum = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (state_q == ST_MLOAD) begin
			mcnt_q <= MCNTW'(SUMW);
		end else if (state_q == ST_MUL) begin
			mcnt_q <= mcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MLOAD) begin
			neg_q  <= sum_q[SUMW-1];
			abs_q  <= abs_sum;
			n_q    <= n_cur;
			nn_q   <= (2*CW)'(n_cur) * (2*CW)'(n_cur);
			mca_q  <= VW'(abs_sum);
			mpa_q  <= abs_sum;
			acca_q <= '0;
			mcb_q  <= VW'(sq_q);
			mpb_q  <= n_cur;
			accb_q <= '0;
		end else if (state_q == ST_MUL) begin
			acca_q <= acca_q + (mpa_q[0] ? mca_q : VW'(0));
			accb_q <= accb_q + (mpb_q[0] ? mcb_q : VW'(0));
			mca_q  <= {mca_q[VW-2:0], 1'b0};
			mcb_q  <= {mcb_q[VW-2:0], 1'b0};
			mpa_q  <= mpa_q >> 1;
			mpb_q  <= mpb_q >> 1;
		end
	end

	// n^2 * variance; clamp tiny negative from nothing (exact math never goes below)
	assign var_num = (accb_q > acca_q) ? (accb_q - acca_q) : VW'(0);

	// mean magnitude: (|sum|*256 + n/2) / n
	rwms_div #(
		.NW(MNW),
		.DW(CW)
	) u_mean_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.num    (MNW'({abs_q, {RWMS_FRAC_W{1'b0}}}) + MNW'(n_q >> 1)),
		.den    (n_q),
		.busy   (md_busy),
		.done   (md_done),
		.quo    (md_quo)
	);

	// variance in Q.16: (n*sumsq - sum^2) * 2^16 / n^2
	rwms_div #(
		.NW(VNW),
		.DW(2 * CW)
	) u_var_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vd_start),
		.num    ({var_num, 16'h0000}),
		.den    (nn_q),
		.busy   (vd_busy),
		.done   (vd_done),
		.quo    (vd_quo)
	);

	rwms_sqrt #(
		.XW(RWMS_X_W)
	) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vd_done),
		.x      (vd_quo[RWMS_X_W-1:0]),
		.done   (rt_done),
		.root   (rt_root)
	);

	// ---------------- output register ----------------
	assign m24 = md_quo[RWMS_MEAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (empty_q) begin
				mean_q      <= '0;
				sd_q        <= '0;
				cnt_q       <= '0;
				empty_res_q <= 1'b1;
			end else begin
				mean_q      <= neg_q ? -m24 : m24;
				sd_q        <= RWMS_SD_W'(rt_root);
				cnt_q       <= RWMS_CNT_W'(n_q);
				empty_res_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign mean         = mean_q;
	assign std_dev      = sd_q;
	assign sample_count = cnt_q;
	assign empty_res    = empty_res_q;

	// ---------------- checks ----------------
	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		md_start |-> !md_busy && !vd_busy)
		else $error("divider restarted while busy");

	a_mean_before_root: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == ST_VDIV)
		else $error("mean divide finished outside the variance phase");

	a_root_after_vdiv: assert property (@(posedge clk) disable iff (!arst_n)
		vd_done |-> state_q == ST_VDIV)
		else $error("variance divide finished outside its phase");

	a_push_reads_ring: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !clear |=> state_q == ST_READ)
		else $error("push did not start the ring read");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> sample_count == '0 && std_dev == '0 && mean == '0)
		else $error("empty result carries data");

	a_wrap_sets_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && wpos_q == PW'(WINDOW_DEPTH - 1) |=> full_q && wpos_q == '0)
		else $error("ring wrap did not mark the window full");

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for rolling_window_mean_stddev_unit.
// Depends on rwms_pkg and the unit RTL; predicts every result word from its own window copy.
module testbench
	import rwms_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = RWMS_DEPTH_DEF;
	localparam int RAND_WORDS = 870;
	localparam int CYCLE_CAP  = 1000000;
	// the drain waits well beyond the time one push needs at depth 32
	localparam int DRAIN_WAIT = 400;

	typedef struct packed {
		logic signed [RWMS_MEAN_W-1:0] mean;
		logic [RWMS_SD_W-1:0]          std_dev;
		logic [RWMS_CNT_W-1:0]         cnt;
		logic                          empty;
	} stats_word_t;

	// directed rows: typed expectation only where it is obvious (empty window)
	typedef struct {
		logic signed [15:0] smp;
		logic               clr;
		bit                 typed;
		stats_word_t        want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample = '0;
	logic clear = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [RWMS_MEAN_W-1:0] mean;
	logic [RWMS_SD_W-1:0] std_dev;
	logic [RWMS_CNT_W-1:0] sample_count;
	logic empty_res;

	always #1 clk = ~clk;

	rolling_window_mean_stddev_unit #(.WINDOW_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample), .clear(clear),
		.out_valid(out_valid), .out_ready(out_ready),
		.mean(mean), .std_dev(std_dev), .sample_count(sample_count), .empty_res(empty_res)
	);

	// predictor state: private copy of the ring and the running sums
	logic signed [15:0] ring [DEPTH];
	int unsigned wr_pos;
	bit ring_full;
	longint win_sum;
	longint unsigned win_sq_sum;

	stats_word_t pending_stats [$];
	int mismatches = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;     // long receiver stall in progress
	bit stim_done = 1'b0;

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// apply one word to the private window and return the stats that follow
	function automatic stats_word_t window_stats(logic signed [15:0] smp, logic clr);
		stats_word_t w;
		longint unsigned n, asum, v, nn, x, sd;
		longint num, m;
		longint old, s;
		if (clr) begin
			wr_pos = 0; ring_full = 0; win_sum = 0; win_sq_sum = 0;
		end else begin
			s = smp;
			if (ring_full) begin
				old = ring[wr_pos];
				win_sum -= old;
				win_sq_sum -= longint'(old * old);
			end
			ring[wr_pos] = smp;
			win_sum += s;
			win_sq_sum += longint'(s * s);
			wr_pos++;
			if (wr_pos >= DEPTH) begin
				wr_pos = 0;
				ring_full = 1;
			end
		end
		n = ring_full ? DEPTH : wr_pos;
		w = '0;
		if (n == 0) begin
			w.empty = 1'b1;
			return w;
		end
		num = win_sum * 256;
		if (num >= 0) m = (longint'(num) + longint'(n / 2)) / longint'(n);
		else m = -((-num + longint'(n / 2)) / longint'(n));
		w.mean = m[RWMS_MEAN_W-1:0];
		asum = win_sum < 0 ? -win_sum : win_sum;
		v = (n * win_sq_sum > asum * asum) ? n * win_sq_sum - asum * asum : 0;
		nn = n * n;
		x = ((v / nn) << 16) + (((v % nn) << 16) / nn);
		sd = root_floor(x);
		w.std_dev = sd > 64'hFFFFFF ? 24'hFFFFFF : sd[23:0];
		w.cnt = n[5:0];
		w.empty = 1'b0;
		return w;
	endfunction

	// send one word; holds valid and payload until accepted
	task automatic send_word(logic signed [15:0] smp, logic clr, bit typed, stats_word_t want);
		stats_word_t pred;
		in_valid <= 1'b1;
		sample <= smp;
		clear <= clr;
		pred = window_stats(smp, clr);
		if (typed && pred !== want)
			$display("directed row disagrees with predictor: typed %h predicted %h", want, pred);
		pending_stats.push_back(typed ? want : pred);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic idle_sender(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// random sample with varied magnitude so both extremes and small values show up
	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom());
		endcase
	endfunction

	// checker: compare every accepted result word with the oldest expectation
	always @(posedge clk) begin
		stats_word_t got, exp_w;
		cycles <= cycles + 1;
		if (arst_n && out_valid && out_ready) begin
			got = '{mean, std_dev, sample_count, empty_res};
			if (pending_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				exp_w = pending_stats.pop_front();
				if (got !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
							exp_w.mean, exp_w.std_dev, exp_w.cnt, exp_w.empty,
							got.mean, got.std_dev, got.cnt, got.empty);
				end
			end
		end
		if (cycles >= CYCLE_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: its own stall pattern, silenced during a long hold-off
	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else if (cycles % 1000 < 300) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	// long receiver stall while the sender keeps offering words
	initial begin
		wait (arst_n);
		repeat (2000) @(negedge clk);
		hold_off = 1'b1;
		repeat (600) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		dir_row_t rows [$];
		stats_word_t empty_w;
		int burst;
		bit drained;
		empty_w = '0;
		empty_w.empty = 1'b1;
		drained = 1'b0;
		// clear on empty window, extremes, clear in the middle
		rows.push_back('{16'sh1234, 1'b1, 1'b1, empty_w});
		rows.push_back('{16'sh7FFF, 1'b0, 1'b0, '0});
		rows.push_back('{16'sh8000, 1'b0, 1'b0, '0});
		rows.push_back('{16'sh0000, 1'b0, 1'b0, '0});
		rows.push_back('{-16'sd1, 1'b0, 1'b0, '0});
		rows.push_back('{16'sh0000, 1'b1, 1'b1, empty_w});
		rows.push_back('{-16'sd3, 1'b0, 1'b0, '0});   // single negative sample
		rows.push_back('{16'sh0000, 1'b0, 1'b0, '0});
		rows.push_back('{16'sh5555, 1'b1, 1'b1, empty_w});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		void'(window_stats(16'sh0, 1'b1));   // predictor starts from an empty window
		@(negedge clk);

		foreach (rows[i]) send_word(rows[i].smp, rows[i].clr, rows[i].typed, rows[i].want);
		// full window of max values, then alternating min and max values: extreme sums and wrap eviction
		for (int i = 0; i < DEPTH + 4; i++) send_word(16'sh7FFF, 1'b0, 0, '0);
		for (int i = 0; i < DEPTH + 2; i++) send_word(i[0] ? 16'sh7FFF : 16'sh8000, 1'b0, 0, '0);

		// random part in bursts; mostly pushes, clears rare so the window fills and wraps
		for (int k = 0; k < RAND_WORDS; ) begin
			burst = $urandom_range(1, 40);
			for (int j = 0; j < burst && k < RAND_WORDS; j++, k++)
				send_word(rand_sample(), ($urandom_range(0, 59) == 0), 0, '0);
			if (!drained && k >= RAND_WORDS / 2) begin
				// sender pauses until the block has drained
				drained = 1'b1;
				in_valid <= 1'b0;
				while (pending_stats.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 150));
		end
		in_valid <= 1'b0;
		while (pending_stats.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
